### rtl/core/rc_pulse_to_motor_drive_macros.svh
// ---------------------------------------------------------------------------
// RC pulse to motor drive: assertion macros
// Shared property forms for the checker; clock and reset are passed in.
// ---------------------------------------------------------------------------
`ifndef RC_PULSE_TO_MOTOR_DRIVE_MACROS_SVH
`define RC_PULSE_TO_MOTOR_DRIVE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RCPM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcpm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RCPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcpm assertion failed");

`endif

### rtl/core/rcpm_pkg.sv
// ---------------------------------------------------------------------------
// RC pulse to motor drive: package
// Widths, stage map, register codes, reset values and item types.
// ---------------------------------------------------------------------------
`default_nettype none

package rcpm_pkg;

  localparam int PULSE_BITS    = 16;
  localparam int DUTY_BITS     = 8;
  localparam int DUTY_REG_BITS = 9;
  localparam int BAND_BITS     = 10;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = PULSE_BITS;

  // Datapath widths
  localparam int OFF_BITS    = PULSE_BITS + 1;
  localparam int DRANGE_BITS = DUTY_REG_BITS + 1;
  localparam int PROD_BITS   = OFF_BITS + DRANGE_BITS;
  localparam int QUO_BITS    = PULSE_BITS + DUTY_REG_BITS;
  localparam int EDGE_BITS   = PULSE_BITS + 2;
  localparam int SUM_BITS    = QUO_BITS + 2;

  // Stage map: clamp, dead band, multiply, magnitude, one stage per quotient
  // bit, signed sum, output
  localparam int ST_CLAMP = 0;
  localparam int ST_BAND  = 1;
  localparam int ST_MUL   = 2;
  localparam int ST_MAG   = 3;
  localparam int ST_DIV0  = 4;
  localparam int ST_SUM   = ST_DIV0 + QUO_BITS;
  localparam int ST_OUT   = ST_SUM + 1;
  localparam int N_STAGES = ST_OUT + 1;

  localparam int OUTQ_DEPTH   = 2;
  localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);
  localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
  localparam int INFLIGHT_BITS = $clog2(N_STAGES + OUTQ_DEPTH + 1);

  localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

  localparam logic [PULSE_BITS-1:0]           MIN_PULSE_RST = PULSE_BITS'(1100);
  localparam logic [PULSE_BITS-1:0]           MAX_PULSE_RST = PULSE_BITS'(1900);
  localparam logic [PULSE_BITS-1:0]           CENTER_RST    = PULSE_BITS'(1500);
  localparam logic [BAND_BITS-1:0]            BAND_RST      = BAND_BITS'(20);
  localparam logic signed [DUTY_REG_BITS-1:0] MIN_DUTY_RST  = DUTY_REG_BITS'(-255);
  localparam logic signed [DUTY_REG_BITS-1:0] MAX_DUTY_RST  = DUTY_REG_BITS'(255);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_PULSE    = CFG_IDX_BITS'(0),
    REG_MAX_PULSE    = CFG_IDX_BITS'(1),
    REG_CENTER_PULSE = CFG_IDX_BITS'(2),
    REG_DEAD_BAND    = CFG_IDX_BITS'(3),
    REG_MIN_DUTY     = CFG_IDX_BITS'(4),
    REG_MAX_DUTY     = CFG_IDX_BITS'(5)
  } cfg_reg_t;

  typedef struct packed {
    logic [PULSE_BITS-1:0] pulse_width_a;
    logic [PULSE_BITS-1:0] pulse_width_b;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty_a;
    logic                 reverse_a;
    logic [DUTY_BITS-1:0] duty_b;
    logic                 reverse_b;
  } out_item_t;

  // Register values and the quantities derived from them
  typedef struct packed {
    logic [PULSE_BITS-1:0]           lo;
    logic [PULSE_BITS-1:0]           hi;
    logic [PULSE_BITS-1:0]           center;
    logic signed [DUTY_REG_BITS-1:0] min_duty;
    logic signed [EDGE_BITS-1:0]     band_lo;
    logic signed [EDGE_BITS-1:0]     band_hi;
    logic signed [DRANGE_BITS-1:0]   drange;
    logic [PULSE_BITS-1:0]           span_mag;
    logic                            span_neg;
    logic                            span_zero;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/core/rcpm_cfg.sv
// ---------------------------------------------------------------------------
// RC pulse to motor drive: configuration registers
// Holds the six registers and registers the span, duty range and band edges.
// ---------------------------------------------------------------------------
`default_nettype none

module rcpm_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [rcpm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [rcpm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output rcpm_pkg::cfg_t                           cfg
);

  logic [rcpm_pkg::PULSE_BITS-1:0]           min_pulse;
  logic [rcpm_pkg::PULSE_BITS-1:0]           max_pulse;
  logic [rcpm_pkg::PULSE_BITS-1:0]           center_pulse;
  logic [rcpm_pkg::BAND_BITS-1:0]            dead_band;
  logic signed [rcpm_pkg::DUTY_REG_BITS-1:0] min_duty;
  logic signed [rcpm_pkg::DUTY_REG_BITS-1:0] max_duty;

  logic signed [rcpm_pkg::EDGE_BITS-1:0]   band_lo;
  logic signed [rcpm_pkg::EDGE_BITS-1:0]   band_hi;
  logic signed [rcpm_pkg::DRANGE_BITS-1:0] drange;
  logic [rcpm_pkg::PULSE_BITS-1:0]         span_mag;
  logic                                    span_neg;
  logic                                    span_zero;

  logic signed [rcpm_pkg::OFF_BITS-1:0] span;
  logic [rcpm_pkg::OFF_BITS-1:0]        span_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse    <= rcpm_pkg::MIN_PULSE_RST;
      max_pulse    <= rcpm_pkg::MAX_PULSE_RST;
      center_pulse <= rcpm_pkg::CENTER_RST;
      dead_band    <= rcpm_pkg::BAND_RST;
      min_duty     <= rcpm_pkg::MIN_DUTY_RST;
      max_duty     <= rcpm_pkg::MAX_DUTY_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rcpm_pkg::REG_MIN_PULSE:    min_pulse    <= cfg_data[rcpm_pkg::PULSE_BITS-1:0];
        rcpm_pkg::REG_MAX_PULSE:    max_pulse    <= cfg_data[rcpm_pkg::PULSE_BITS-1:0];
        rcpm_pkg::REG_CENTER_PULSE: center_pulse <= cfg_data[rcpm_pkg::PULSE_BITS-1:0];
        rcpm_pkg::REG_DEAD_BAND:    dead_band    <= cfg_data[rcpm_pkg::BAND_BITS-1:0];
        rcpm_pkg::REG_MIN_DUTY:     min_duty     <= $signed(cfg_data[rcpm_pkg::DUTY_REG_BITS-1:0]);
        rcpm_pkg::REG_MAX_DUTY:     max_duty     <= $signed(cfg_data[rcpm_pkg::DUTY_REG_BITS-1:0]);
        default: ;
      endcase
    end
  end

  assign span = $signed({1'b0, max_pulse}) - $signed({1'b0, min_pulse});
  assign span_abs = span[rcpm_pkg::OFF_BITS-1] ? -span : span;

  // Derived values are registered and follow the registers in the next cycle;
  // the dead band and divider stages read them well after an item enters.
  always_ff @(posedge clk) begin
    band_lo   <= $signed({2'b00, center_pulse}) -
                 $signed(rcpm_pkg::EDGE_BITS'(dead_band));
    band_hi   <= $signed({2'b00, center_pulse}) +
                 $signed(rcpm_pkg::EDGE_BITS'(dead_band));
    drange    <= rcpm_pkg::DRANGE_BITS'(max_duty) - rcpm_pkg::DRANGE_BITS'(min_duty);
    span_mag  <= span_abs[rcpm_pkg::PULSE_BITS-1:0];
    span_neg  <= span[rcpm_pkg::OFF_BITS-1];
    span_zero <= (max_pulse == min_pulse);
  end

  assign cfg.lo        = min_pulse;
  assign cfg.hi        = max_pulse;
  assign cfg.center    = center_pulse;
  assign cfg.min_duty  = min_duty;
  assign cfg.band_lo   = band_lo;
  assign cfg.band_hi   = band_hi;
  assign cfg.drange    = drange;
  assign cfg.span_mag  = span_mag;
  assign cfg.span_neg  = span_neg;
  assign cfg.span_zero = span_zero;

endmodule

`default_nettype wire

### rtl/core/rcpm_ctrl.sv
// ---------------------------------------------------------------------------
// RC pulse to motor drive: pipeline control
// Carries a valid bit per stage and moves the whole pipe while the output
// queue has room.
// ---------------------------------------------------------------------------
`default_nettype none

module rcpm_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           q_full,
  output logic [rcpm_pkg::N_STAGES-1:0]       en,
  output logic                                push
);

  logic [rcpm_pkg::N_STAGES-1:0] v;
  logic                          advance;

  assign advance  = !q_full;
  assign in_ready = advance && !rst;
  assign push     = advance && v[rcpm_pkg::N_STAGES-1];

  // Load a stage only when real data moves into it
  assign en = {rcpm_pkg::N_STAGES{advance}} & {v[rcpm_pkg::N_STAGES-2:0], in_ready && in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (advance) begin
      v <= {v[rcpm_pkg::N_STAGES-2:0], in_valid};
    end
  end

endmodule

`default_nettype wire

### rtl/core/rcpm_chan.sv
// ---------------------------------------------------------------------------
// RC pulse to motor drive: channel datapath
// Clamp, dead band, scale, pipelined restoring divide, offset and saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module rcpm_chan (
  input  wire logic                                clk,
  input  wire logic [rcpm_pkg::N_STAGES-1:0]       en,
  input  wire logic [rcpm_pkg::PULSE_BITS-1:0]     pulse_width,
  input  wire rcpm_pkg::cfg_t                      cfg,
  output logic [rcpm_pkg::DUTY_BITS-1:0]           duty,
  output logic                                     reverse
);

  localparam int PB = rcpm_pkg::PULSE_BITS;
  localparam int QB = rcpm_pkg::QUO_BITS;

  // Clamp
  logic [PB-1:0] w_floor;
  logic [PB-1:0] w_ceil;
  logic [PB-1:0] w_clamp;

  // Floor first, then ceiling, so a floor above the ceiling ends at the ceiling
  assign w_floor = (pulse_width < cfg.lo) ? cfg.lo : pulse_width;
  assign w_ceil  = (w_floor > cfg.hi) ? cfg.hi : w_floor;

  always_ff @(posedge clk) begin
    if (en[rcpm_pkg::ST_CLAMP]) begin
      w_clamp <= w_ceil;
    end
  end

  // Dead band and offset from the floor
  logic signed [rcpm_pkg::EDGE_BITS-1:0] w_ext;
  logic                                  in_band;
  logic [PB-1:0]                         w_band;
  logic signed [rcpm_pkg::OFF_BITS-1:0]  offset;

  assign w_ext   = $signed({2'b00, w_clamp});
  assign in_band = (w_ext < $signed(cfg.band_hi)) && (w_ext > $signed(cfg.band_lo));
  assign w_band  = in_band ? cfg.center : w_clamp;

  always_ff @(posedge clk) begin
    if (en[rcpm_pkg::ST_BAND]) begin
      offset <= $signed({1'b0, w_band}) - $signed({1'b0, cfg.lo});
    end
  end

  // Scale by the duty range
  logic signed [rcpm_pkg::PROD_BITS-1:0] prod;

  always_ff @(posedge clk) begin
    if (en[rcpm_pkg::ST_MUL]) begin
      prod <= offset * $signed(cfg.drange);
    end
  end

  // Split into sign and magnitude for the unsigned divider
  logic [rcpm_pkg::PROD_BITS-1:0] prod_abs;

  logic [PB-1:0] rem    [0:QB-1];
  logic [QB-1:0] dq     [0:QB];
  logic          neg_q  [0:QB];
  logic          zero_q [0:QB];

  assign prod_abs = prod[rcpm_pkg::PROD_BITS-1] ? -prod : prod;

  always_ff @(posedge clk) begin
    if (en[rcpm_pkg::ST_MAG]) begin
      rem[0]    <= '0;
      dq[0]     <= prod_abs[QB-1:0];
      neg_q[0]  <= prod[rcpm_pkg::PROD_BITS-1] ^ cfg.span_neg;
      zero_q[0] <= cfg.span_zero;
    end
  end

  // One quotient bit per stage: dividend bits shift out at the top of dq
  // while quotient bits shift in at the bottom.
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [PB:0]   trial;
    logic          ge;
    logic [PB:0]   diff;

    assign trial = {rem[k], dq[k][QB-1]};
    assign ge    = (trial >= {1'b0, cfg.span_mag});
    assign diff  = trial - {1'b0, cfg.span_mag};

    always_ff @(posedge clk) begin
      if (en[rcpm_pkg::ST_DIV0 + k]) begin
        dq[k+1]     <= {dq[k][QB-2:0], ge};
        neg_q[k+1]  <= neg_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end

    if (k < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[rcpm_pkg::ST_DIV0 + k]) begin
          rem[k+1] <= ge ? diff[PB-1:0] : trial[PB-1:0];
        end
      end
    end
  end

  // Apply the sign and add the duty floor; a zero span gives the floor
  logic signed [QB:0]                   q_signed;
  logic signed [rcpm_pkg::SUM_BITS-1:0] sum;

  assign q_signed = neg_q[QB] ? -$signed({1'b0, dq[QB]}) : $signed({1'b0, dq[QB]});

  always_ff @(posedge clk) begin
    if (en[rcpm_pkg::ST_SUM]) begin
      if (zero_q[QB]) begin
        sum <= rcpm_pkg::SUM_BITS'($signed(cfg.min_duty));
      end else begin
        sum <= rcpm_pkg::SUM_BITS'(q_signed) +
               rcpm_pkg::SUM_BITS'($signed(cfg.min_duty));
      end
    end
  end

  // Direction from the sign, magnitude saturated
  logic [rcpm_pkg::SUM_BITS-1:0] mag;

  assign mag = sum[rcpm_pkg::SUM_BITS-1] ? -sum : sum;

  always_ff @(posedge clk) begin
    if (en[rcpm_pkg::ST_OUT]) begin
      reverse <= sum[rcpm_pkg::SUM_BITS-1];
      duty    <= (mag > rcpm_pkg::SUM_BITS'(rcpm_pkg::DUTY_MAX)) ?
                 rcpm_pkg::DUTY_MAX : mag[rcpm_pkg::DUTY_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/core/rcpm_outq.sv
// ---------------------------------------------------------------------------
// RC pulse to motor drive: output queue
// Two-entry queue that decouples the pipe from a stalling receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module rcpm_outq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire rcpm_pkg::out_item_t push_item,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rcpm_pkg::out_item_t      out_item
);

  rcpm_pkg::out_item_t entry [0:rcpm_pkg::OUTQ_DEPTH-1];

  logic [rcpm_pkg::OUTQ_PTR_BITS-1:0] wr_ptr;
  logic [rcpm_pkg::OUTQ_PTR_BITS-1:0] rd_ptr;
  logic [rcpm_pkg::OUTQ_CNT_BITS-1:0] count;
  logic                               pop;

  assign full      = (count == rcpm_pkg::OUTQ_CNT_BITS'(rcpm_pkg::OUTQ_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = entry[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/rc_pulse_to_motor_drive.sv
// ---------------------------------------------------------------------------
// RC pulse to motor drive
// Two RC pulse widths in, duty magnitude and direction for two motors out.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request: both pulse widths. out_valid/
//   out_ready carry the matching duty and direction pair, in request order.
//   Registers are written through cfg_wr_en/cfg_index/cfg_data while no
//   request is in flight; writes to unused indices are dropped.
//   From acceptance to out_valid a request passes the clamp, dead band,
//   multiply, magnitude, 25 divider stages (one quotient bit each), sum and
//   output register, then the output queue. The divider pipe sets the depth.
//   Throughput is one request per cycle while the receiver keeps up.
//   Reset clears every valid bit and the queue and loads the default
//   registers; in_ready is low during reset.
//   When the receiver stalls, results collect in a two-entry queue; the pipe
//   keeps accepting until the queue fills, then holds everything in place.
// ---------------------------------------------------------------------------
`default_nettype none

module rc_pulse_to_motor_drive (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire rcpm_pkg::in_item_t                  in_item,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output rcpm_pkg::out_item_t                      out_item,
  input  wire logic                                cfg_wr_en,
  input  wire logic [rcpm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [rcpm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  rcpm_pkg::cfg_t                cfg;
  logic [rcpm_pkg::N_STAGES-1:0] en;
  logic                          push;
  logic                          q_full;
  rcpm_pkg::out_item_t           push_item;

  rcpm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rcpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_full   (q_full),
    .en       (en),
    .push     (push)
  );

  rcpm_chan u_chan_a (
    .clk         (clk),
    .en          (en),
    .pulse_width (in_item.pulse_width_a),
    .cfg         (cfg),
    .duty        (push_item.duty_a),
    .reverse     (push_item.reverse_a)
  );

  rcpm_chan u_chan_b (
    .clk         (clk),
    .en          (en),
    .pulse_width (in_item.pulse_width_b),
    .cfg         (cfg),
    .duty        (push_item.duty_b),
    .reverse     (push_item.reverse_b)
  );

  rcpm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### rtl/core/rcpm_checker.sv
// ---------------------------------------------------------------------------
// RC pulse to motor drive: port checker
// Watches the top-level ports for stalls, phantom results and capacity.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rc_pulse_to_motor_drive_macros.svh"

module rcpm_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire rcpm_pkg::out_item_t out_item
);

  localparam int CAP = rcpm_pkg::N_STAGES + rcpm_pkg::OUTQ_DEPTH;

  logic [rcpm_pkg::INFLIGHT_BITS-1:0] outstanding;
  logic                               in_acc;
  logic                               out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count requests taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      unique case ({in_acc, out_acc})
        2'b10:   outstanding <= outstanding + 1'b1;
        2'b01:   outstanding <= outstanding - 1'b1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  `RCPM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item))
  `RCPM_ASSERT_IMP(a_no_phantom, clk, rst, out_valid, outstanding != '0)
  `RCPM_ASSERT_IMP(a_open_when_empty, clk, rst, !out_valid, in_ready)
  `RCPM_ASSERT_IMP(a_capacity, clk, rst, 1'b1, outstanding <= rcpm_pkg::INFLIGHT_BITS'(CAP))
  `RCPM_ASSERT_IMP(a_reset_idle, clk, rst, $past(rst), !out_valid)

endmodule

bind rc_pulse_to_motor_drive rcpm_checker u_checker (.*);

`default_nettype wire

### verif/rc_pulse_to_motor_drive_test.sv
// ---------------------------------------------------------------------------
// RC pulse to motor drive: self-checking testbench
// Drives pulse-width requests through the block under a series of register
// settings, predicts each motor's duty and direction in the bench, and
// compares every result in order. Both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module rc_pulse_to_motor_drive_test;
  import rcpm_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = 40;
  localparam int HOLD_CYCLES      = 300;
  localparam int PHASE_COUNT      = 10;
  localparam int REQS_PER_PHASE   = 180;
  localparam int STALL_BURST_REQS = 80;
  localparam int SPARE_IDX_FIRST  = int'(REG_MAX_DUTY) + 1;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

  typedef struct {
    logic [PULSE_BITS-1:0]           lo;
    logic [PULSE_BITS-1:0]           hi;
    logic [PULSE_BITS-1:0]           center;
    logic [BAND_BITS-1:0]            band;
    logic signed [DUTY_REG_BITS-1:0] min_duty;
    logic signed [DUTY_REG_BITS-1:0] max_duty;
  } drive_settings_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_item_t                 in_item = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_item;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  drive_settings_t active_cfg;
  out_item_t       pending_drive[$];
  out_item_t       drive_want;
  int              mismatch_count = 0;
  int              request_count = 0;
  int              settings_count = 0;
  int              input_stall_cycles = 0;
  int              cycle_count = 0;

  // Receiver hold-off handshake: the test raises hold_req, the receiver
  // counts the hold itself and then catches hold_done up.
  int              hold_req = 0;
  int              hold_done = 0;
  int              hold_left = 0;
  int              rx_tick = 0;
  rx_mode_t        rx_mode = RX_STEADY;

  rc_pulse_to_motor_drive u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rc_pulse_to_motor_drive_test failed");
      $finish;
    end
  end

  // ---- predictor ----

  function automatic void drive_channel(input logic [PULSE_BITS-1:0] width,
                                        output logic [DUTY_BITS-1:0] duty,
                                        output logic reverse);
    longint w, lo, hi, c, db, span, dmin, dmax, d;
    w    = longint'(width);
    lo   = longint'(active_cfg.lo);
    hi   = longint'(active_cfg.hi);
    c    = longint'(active_cfg.center);
    db   = longint'(active_cfg.band);
    dmin = longint'(active_cfg.min_duty);
    dmax = longint'(active_cfg.max_duty);
    span = hi - lo;
    // Floor first, then ceiling: a floor above the ceiling lands on the ceiling
    if (w < lo) w = lo;
    if (w > hi) w = hi;
    if (w < c + db && w > c - db) w = c;
    if (span == 0) d = dmin;
    else d = ((w - lo) * (dmax - dmin)) / span + dmin;
    reverse = (d < 0);
    if (d < 0) d = -d;
    if (d > longint'(DUTY_MAX)) d = longint'(DUTY_MAX);
    duty = d[DUTY_BITS-1:0];
  endfunction

  function automatic out_item_t predict_drive(input in_item_t req);
    out_item_t res;
    drive_channel(req.pulse_width_a, res.duty_a, res.reverse_a);
    drive_channel(req.pulse_width_b, res.duty_b, res.reverse_b);
    return res;
  endfunction

  function automatic void store_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_MIN_PULSE:    active_cfg.lo = data[PULSE_BITS-1:0];
      REG_MAX_PULSE:    active_cfg.hi = data[PULSE_BITS-1:0];
      REG_CENTER_PULSE: active_cfg.center = data[PULSE_BITS-1:0];
      REG_DEAD_BAND:    active_cfg.band = data[BAND_BITS-1:0];
      REG_MIN_DUTY:     active_cfg.min_duty = data[DUTY_REG_BITS-1:0];
      REG_MAX_DUTY:     active_cfg.max_duty = data[DUTY_REG_BITS-1:0];
      default: ;
    endcase
  endfunction

  // ---- stimulus helpers ----

  function automatic drive_settings_t pick_settings(input int phase);
    drive_settings_t s;
    s.lo       = PULSE_BITS'($urandom);
    s.hi       = PULSE_BITS'($urandom);
    s.center   = PULSE_BITS'($urandom);
    s.band     = BAND_BITS'($urandom);
    s.min_duty = DUTY_REG_BITS'($urandom);
    s.max_duty = DUTY_REG_BITS'($urandom);
    case (phase)
      0: begin
        s.lo = '0; s.hi = '1; s.center = 16'h8000; s.band = '1;
        s.min_duty = 9'sh100; s.max_duty = 9'sd255;
      end
      1: begin
        s.lo = '1; s.hi = '0; s.center = '0; s.band = '0;
        s.min_duty = 9'sd255; s.max_duty = 9'sh100;
      end
      2: begin
        s.lo = '0; s.hi = '0; s.center = '0; s.band = '0;
        s.min_duty = '0; s.max_duty = '0;
      end
      3: s.hi = s.lo;
      4, 5, 6: begin
        s.lo       = PULSE_BITS'($urandom_range(1200, 900));
        s.hi       = PULSE_BITS'($urandom_range(2100, 1800));
        s.center   = PULSE_BITS'($urandom_range(1600, 1400));
        s.band     = BAND_BITS'($urandom_range(60));
        s.min_duty = 9'(-int'($urandom_range(255)));
        s.max_duty = 9'($urandom_range(255));
        // Reverse the sense of the stick on one phase
        if (phase == 6) begin
          s.min_duty = -s.min_duty;
          s.max_duty = -s.max_duty;
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [PULSE_BITS-1:0] pick_width();
    int anchor;
    case ($urandom_range(5))
      0: return PULSE_BITS'($urandom);
      1: anchor = int'(active_cfg.lo);
      2: anchor = int'(active_cfg.hi);
      3: anchor = $urandom_range(1) ? int'(active_cfg.center) + int'(active_cfg.band)
                                    : int'(active_cfg.center) - int'(active_cfg.band);
      default: return PULSE_BITS'($urandom_range(active_cfg.hi, active_cfg.lo));
    endcase
    return PULSE_BITS'(anchor + int'($urandom_range(6)) - 3);
  endfunction

  function automatic in_item_t pick_request();
    in_item_t req;
    req.pulse_width_a = pick_width();
    req.pulse_width_b = pick_width();
    return req;
  endfunction

  // Called at a rising edge; returns at the edge that takes the request, with
  // in_valid still high so that a following request can go straight out.
  task automatic send_request(input in_item_t req);
    in_valid <= 1'b1;
    in_item  <= req;
    @(negedge clk);
    while (!in_ready) begin
      input_stall_cycles++;
      @(negedge clk);
    end
    @(posedge clk);
    pending_drive.push_back(predict_drive(req));
    request_count++;
  endtask

  task automatic send_pair(input logic [PULSE_BITS-1:0] a, input logic [PULSE_BITS-1:0] b);
    in_item_t req;
    req.pulse_width_a = a;
    req.pulse_width_b = b;
    send_request(req);
  endtask

  task automatic idle_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    store_reg(idx, data);
  endtask

  // Unused high bits of the narrow registers carry noise
  task automatic load_settings(input drive_settings_t s);
    logic [CFG_DATA_BITS-1:0] band_word, min_word, max_word;
    band_word = CFG_DATA_BITS'($urandom);
    min_word  = CFG_DATA_BITS'($urandom);
    max_word  = CFG_DATA_BITS'($urandom);
    band_word[BAND_BITS-1:0]    = s.band;
    min_word[DUTY_REG_BITS-1:0] = s.min_duty;
    max_word[DUTY_REG_BITS-1:0] = s.max_duty;
    write_reg(REG_MIN_PULSE, s.lo);
    write_reg(REG_MAX_PULSE, s.hi);
    write_reg(REG_CENTER_PULSE, s.center);
    write_reg(REG_DEAD_BAND, band_word);
    write_reg(REG_MIN_DUTY, min_word);
    write_reg(REG_MAX_DUTY, max_word);
    cfg_wr_en <= 1'b0;
    settings_count++;
  endtask

  task automatic load_fields(input logic [PULSE_BITS-1:0] lo, input logic [PULSE_BITS-1:0] hi,
                             input logic [PULSE_BITS-1:0] center,
                             input logic [BAND_BITS-1:0] band,
                             input logic signed [DUTY_REG_BITS-1:0] min_duty,
                             input logic signed [DUTY_REG_BITS-1:0] max_duty);
    drive_settings_t s;
    s.lo = lo; s.hi = hi; s.center = center; s.band = band;
    s.min_duty = min_duty; s.max_duty = max_duty;
    load_settings(s);
  endtask

  // ---- receiver ----

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      rx_tick   <= 0;
      rx_mode   <= RX_STEADY;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
      if (hold_left == 1) hold_done <= hold_done + 1;
    end else if (hold_req != hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 150 == 149) rx_mode <= rx_mode_t'($urandom_range(3));
      case (rx_mode)
        RX_STEADY:   out_ready <= 1'b1;
        RX_COIN:     out_ready <= 1'($urandom_range(1));
        RX_MOSTLY:   out_ready <= ($urandom_range(9) != 0);
        RX_PERIODIC: out_ready <= (rx_tick % 8) < 5;
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  // Sample mid-cycle: the values seen here are the ones the next edge takes
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_drive.size() == 0) begin
        $error("unexpected result: duty_a %0d reverse_a %0d duty_b %0d reverse_b %0d",
               out_item.duty_a, out_item.reverse_a, out_item.duty_b, out_item.reverse_b);
        mismatch_count++;
      end else begin
        drive_want = pending_drive.pop_front();
        if (out_item.duty_a !== drive_want.duty_a) begin
          $error("duty_a: expected %0d, got %0d", drive_want.duty_a, out_item.duty_a);
          mismatch_count++;
        end
        if (out_item.reverse_a !== drive_want.reverse_a) begin
          $error("reverse_a: expected %0d, got %0d", drive_want.reverse_a, out_item.reverse_a);
          mismatch_count++;
        end
        if (out_item.duty_b !== drive_want.duty_b) begin
          $error("duty_b: expected %0d, got %0d", drive_want.duty_b, out_item.duty_b);
          mismatch_count++;
        end
        if (out_item.reverse_b !== drive_want.reverse_b) begin
          $error("reverse_b: expected %0d, got %0d", drive_want.reverse_b, out_item.reverse_b);
          mismatch_count++;
        end
      end
    end
  end

  // ---- tests ----

  // Reset values: full stick travel, clamps and the edges of the dead band
  task automatic test_default_mapping();
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'd1100, 16'd1900);
    send_pair(16'd1500, 16'd1481);
    send_pair(16'd1519, 16'd1480);
    send_pair(16'd1520, 16'd1300);
    send_pair(16'd1700, 16'd1099);
    send_pair(16'd1901, 16'd1101);
    wait_drained();
  endtask

  task automatic test_corner_settings();
    // Floor above ceiling: every width ends at the ceiling
    load_fields(16'd2000, 16'd1000, 16'd1500, 10'd0, -9'sd255, 9'sd255);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'd1500, 16'd2000);
    wait_drained();
    // Dead band reaching below zero, with the duty range inverted
    load_fields(16'd0, 16'd1000, 16'd5, 10'd1023, 9'sd200, -9'sd200);
    send_pair(16'd0, 16'd4);
    send_pair(16'd1000, 16'd1028);
    send_pair(16'd1027, 16'd500);
    wait_drained();
    // Zero span, magnitude of the minimum duty saturates
    load_fields(16'd1500, 16'd1500, 16'd1500, 10'd20, 9'sh100, 9'sd255);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'd1500, 16'd1499);
    wait_drained();
    // Centre below the floor: forced widths map past the duty range
    load_fields(16'd1000, 16'd2000, 16'd500, 10'd600, -9'sd255, 9'sd255);
    send_pair(16'd1000, 16'd1099);
    send_pair(16'd1100, 16'd2000);
    wait_drained();
  endtask

  // Writes to unused indices must leave every register alone
  task automatic test_register_writes();
    load_settings(pick_settings(4));
    @(posedge clk);
    for (int idx = SPARE_IDX_FIRST; idx < (1 << CFG_IDX_BITS); idx++)
      write_reg(CFG_IDX_BITS'(idx), CFG_DATA_BITS'($urandom));
    cfg_wr_en <= 1'b0;
    repeat (3) send_request(pick_request());
    wait_drained();
  endtask

  // Hold the receiver off long enough that the pipe and queue fill
  task automatic test_input_stall();
    hold_req = hold_req + 1;
    repeat (STALL_BURST_REQS) send_request(pick_request());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int left, burst, gap;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      load_settings(pick_settings(phase));
      left = REQS_PER_PHASE;
      while (left > 0) begin
        burst = $urandom_range(24, 1);
        for (int k = 0; k < burst && left > 0; k++) begin
          send_request(pick_request());
          left--;
        end
        gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
        if (gap != 0) idle_input(gap);
      end
      wait_drained();
    end
  endtask

  initial begin
    active_cfg.lo       = MIN_PULSE_RST;
    active_cfg.hi       = MAX_PULSE_RST;
    active_cfg.center   = CENTER_RST;
    active_cfg.band     = BAND_RST;
    active_cfg.min_duty = MIN_DUTY_RST;
    active_cfg.max_duty = MAX_DUTY_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_mapping();
    test_corner_settings();
    test_register_writes();
    test_input_stall();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests over %0d register settings plus reset values",
             request_count, settings_count);
    $display("input held off for %0d cycles, %0d long receiver hold-offs",
             input_stall_cycles, hold_done);
    if (mismatch_count == 0) begin
      $display("rc_pulse_to_motor_drive_test passed");
    end else begin
      $display("rc_pulse_to_motor_drive_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### rc_pulse_to_motor_drive.f
+incdir+rtl/core
rtl/core/rcpm_pkg.sv
rtl/core/rcpm_cfg.sv
rtl/core/rcpm_ctrl.sv
rtl/core/rcpm_chan.sv
rtl/core/rcpm_outq.sv
rtl/core/rc_pulse_to_motor_drive.sv
rtl/core/rcpm_checker.sv
verif/rc_pulse_to_motor_drive_test.sv
